FILE: rtl/rpw_pkg.sv
// shared types and constants for the per-channel replay window unit
package rpw_pkg;

  localparam int CH_W             = 3;
  localparam int SEQ_W            = 32;
  localparam int DISP_W           = 2;
  localparam int WINDOW_SPAN      = 32;
  localparam int SHIFT_W          = $clog2(WINDOW_SPAN);
  localparam int CH_EXT_W         = 5;
  localparam int DEF_NUM_CHANNELS = 4;

  typedef enum logic [DISP_W-1:0] {
    DISP_NEW   = 2'd0,
    DISP_DUP   = 2'd1,
    DISP_STALE = 2'd2
  } disp_e;

  typedef struct packed {
    logic                   valid;
    logic [SEQ_W-1:0]       newest;
    logic [WINDOW_SPAN-1:0] seen;
  } chan_st_t;

  typedef struct packed {
    logic     wr;
    chan_st_t st;
  } chan_upd_t;

endpackage

FILE: rtl/rpw_if.sv
// valid/ready channel interfaces for packet requests and dispositions
interface rpw_req_if;
  import rpw_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [SEQ_W-1:0] sequence_req;

  modport source (output valid, output channel, output sequence_req, input ready);
  modport sink   (input valid, input channel, input sequence_req, output ready);
endinterface

interface rpw_rsp_if;
  import rpw_pkg::*;

  logic              valid;
  logic              ready;
  logic [DISP_W-1:0] disposition;

  modport source (output valid, output disposition, input ready);
  modport sink   (input valid, input disposition, output ready);
endinterface

FILE: rtl/rpw_state.sv
// per-channel window state: started flag, newest sequence and seen map
module rpw_state #(
  parameter int NUM_CHANNELS = rpw_pkg::DEF_NUM_CHANNELS,
  parameter int ChIdxW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ChIdxW-1:0]  idx_i,
  input  rpw_pkg::chan_upd_t upd_i,
  output rpw_pkg::chan_st_t  st_o
);
  import rpw_pkg::*;

  logic                   valid_q  [NUM_CHANNELS];
  logic [SEQ_W-1:0]       newest_q [NUM_CHANNELS];
  logic [WINDOW_SPAN-1:0] seen_q   [NUM_CHANNELS];

  always_comb begin
    st_o.valid  = valid_q[idx_i];
    st_o.newest = newest_q[idx_i];
    st_o.seen   = seen_q[idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (upd_i.wr) begin
      valid_q[idx_i] <= upd_i.st.valid;
    end
  end

  // contents only matter once the started flag is set
  always_ff @(posedge clk_i) begin
    if (upd_i.wr) begin
      newest_q[idx_i] <= upd_i.st.newest;
      seen_q[idx_i]   <= upd_i.st.seen;
    end
  end

endmodule

FILE: rtl/rpw_classify.sv
// classifies one packet against its channel window and forms the next window
module rpw_classify (
  input  logic [rpw_pkg::SEQ_W-1:0] seq_i,
  input  logic                      chan_ok_i,
  input  rpw_pkg::chan_st_t         st_i,
  output rpw_pkg::disp_e            disp_o,
  output rpw_pkg::chan_upd_t        upd_o
);
  import rpw_pkg::*;

  logic [SEQ_W-1:0]       diff;
  logic [SEQ_W-1:0]       back;
  logic [SHIFT_W-1:0]     adv_sh;
  logic [SHIFT_W-1:0]     back_sh;
  logic [WINDOW_SPAN:0]   adv_wide;
  logic [WINDOW_SPAN-1:0] adv_map;
  logic [WINDOW_SPAN-1:0] back_bit;
  logic                   adv_near;
  logic                   back_near;

  assign diff      = seq_i - st_i.newest;
  assign back      = st_i.newest - seq_i;
  assign adv_sh    = diff[SHIFT_W-1:0] - SHIFT_W'(1);
  assign back_sh   = back[SHIFT_W-1:0] - SHIFT_W'(1);
  // shifting {map, 1} by d-1 gives map << d with the old newest at bit d-1
  assign adv_wide  = {st_i.seen, 1'b1} << adv_sh;
  assign adv_map   = adv_wide[WINDOW_SPAN-1:0];
  assign back_bit  = WINDOW_SPAN'(1) << back_sh;
  assign adv_near  = diff <= SEQ_W'(WINDOW_SPAN);
  assign back_near = back <= SEQ_W'(WINDOW_SPAN);

  always_comb begin
    disp_o = DISP_STALE;
    upd_o  = '{wr: 1'b0, st: st_i};
    if (!chan_ok_i) begin
      disp_o = DISP_STALE;
    end else if (!st_i.valid) begin
      disp_o = DISP_NEW;
      upd_o  = '{wr: 1'b1, st: '{valid: 1'b1, newest: seq_i, seen: '0}};
    end else if (diff == '0) begin
      disp_o = DISP_DUP;
    end else if (!diff[SEQ_W-1]) begin
      disp_o           = DISP_NEW;
      upd_o.wr         = 1'b1;
      upd_o.st.newest  = seq_i;
      upd_o.st.seen    = adv_near ? adv_map : '0;
    end else if (!back_near) begin
      disp_o = DISP_STALE;
    end else if ((st_i.seen & back_bit) != '0) begin
      disp_o = DISP_DUP;
    end else begin
      disp_o        = DISP_NEW;
      upd_o.wr      = 1'b1;
      upd_o.st.seen = st_i.seen | back_bit;
    end
  end

endmodule

FILE: rtl/per_channel_replay_window_unit.sv
// top level of the per-channel anti-replay sliding window
// Each request beat carries a channel and a 32-bit sequence number; each gives
// exactly one response beat with disposition new, duplicate or stale (stale also
// covers a channel at or above NUM_CHANNELS, which leaves all state alone). A
// channel's first packet starts its window. Later packets compare against the
// newest sequence with a wrap-around signed difference and a 32-entry seen map.
// Throughput is one beat per cycle while the response side is not stalled: the
// classify logic sits between the request register and the response register
// and reads and writes the per-channel state in the same cycle, so back-to-back
// packets on one channel need no bypass. A request beat is taken into the request
// register, is classified there and moves to the response register, from which
// its response beat leaves. The response register lets a new request be taken
// while a finished response waits; with both registers full and the response
// stalled, request ready stays low until the response beat leaves.
module per_channel_replay_window_unit #(
  parameter int NUM_CHANNELS = rpw_pkg::DEF_NUM_CHANNELS
) (
  input logic   clk_i,
  input logic   rst_ni,
  rpw_req_if.sink   req_i,
  rpw_rsp_if.source rsp_o
);
  import rpw_pkg::*;

  localparam int ChIdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // request register
  logic             a_valid_q;
  logic [CH_W-1:0]  a_ch_q;
  logic [SEQ_W-1:0] a_seq_q;

  // response register
  logic  b_valid_q;
  disp_e b_disp_q;

  logic                accept;
  logic                a_adv;
  logic [CH_EXT_W-1:0] ch_ext;
  logic                chan_ok;
  logic [ChIdxW-1:0]   ch_idx;
  chan_st_t            cur_st;
  chan_upd_t           cls_upd;
  chan_upd_t           st_upd;
  disp_e               cls_disp;

  // request moves on whenever the response register is empty or draining
  assign a_adv       = a_valid_q && (!b_valid_q || rsp_o.ready);
  assign req_i.ready = !a_valid_q || a_adv;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_ch_q  <= req_i.channel;
      a_seq_q <= req_i.sequence_req;
    end
  end

  // channel range check done on a widened copy so channel counts up to 31 fit
  assign ch_ext  = {{(CH_EXT_W-CH_W){1'b0}}, a_ch_q};
  assign chan_ok = ch_ext < CH_EXT_W'(NUM_CHANNELS);
  assign ch_idx  = ch_ext[ChIdxW-1:0];

  rpw_state #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .ChIdxW       (ChIdxW)
  ) u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (ch_idx),
    .upd_i  (st_upd),
    .st_o   (cur_st)
  );

  rpw_classify u_classify (
    .seq_i     (a_seq_q),
    .chan_ok_i (chan_ok),
    .st_i      (cur_st),
    .disp_o    (cls_disp),
    .upd_o     (cls_upd)
  );

  // state commits only in the cycle the beat leaves the request register
  always_comb begin
    st_upd    = cls_upd;
    st_upd.wr = cls_upd.wr && a_adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_adv) begin
      b_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_disp_q <= cls_disp;
    end
  end

  assign rsp_o.valid       = b_valid_q;
  assign rsp_o.disposition = b_disp_q;

endmodule

FILE: rtl/rpw_checker.sv
// port-level checks for the replay window unit, bound to the top level
module rpw_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rpw_pkg::DISP_W-1:0] out_disp_i
);
  import rpw_pkg::*;

  // stalled response holds its disposition
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_disp_i)))
    else $error("response changed while stalled");

  // only the three defined dispositions appear
  a_disp_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_disp_i == DISP_NEW || out_disp_i == DISP_DUP ||
                     out_disp_i == DISP_STALE))
    else $error("undefined disposition code");

  // an empty response side means the request register can always take a beat
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request stalled with no pending response");

  // a response appears only for a request taken earlier through both registers
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("response without a matching request");

endmodule

bind per_channel_replay_window_unit rpw_checker u_rpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_disp_i  (rsp_o.disposition)
);
